// ===== sv/cpt_pkg.sv =====
package cpt_pkg;

	localparam int TASKS_DEF = 64;
	localparam int ID_W      = 8;
	localparam int MASK_W    = 16;

	typedef enum logic [2:0] {
		CMD_CREATE  = 3'd0,
		CMD_DESTROY = 3'd1,
		CMD_GRANT   = 3'd2,
		CMD_REVOKE  = 3'd3,
		CMD_CHECK   = 3'd4,
		CMD_GET     = 3'd5
	} cmd_t;

	localparam logic [MASK_W-1:0] CAP_SPAWN       = 16'h0100;
	localparam logic [MASK_W-1:0] CAP_GRANT       = 16'h0400;
	localparam logic [MASK_W-1:0] CAP_REVOKE      = 16'h0800;
	localparam logic [MASK_W-1:0] CAP_KERNEL      = 16'h1000;
	localparam logic [MASK_W-1:0] CAP_ALL         = 16'hFFFF;

	localparam int KERNEL_BIT = 12;

	typedef struct packed {
		logic              active;
		logic [MASK_W-1:0] mask;
	} entry_t;

endpackage

// ===== sv/capability_permission_table.sv =====
// Capability permission table: one entry per task, holding a 16-bit
// capability mask and an active flag.
//
// Input channel (in_valid / in_ready) takes one command word: cmd, actor_id,
// subject_id and perm_mask. Output channel (out_valid / out_ready) returns
// one result word per command: status, allowed and caps_out.
//
// The table sits in a memory with one registered read port and one write
// port. For a command, the accept cycle reads the actor entry,
// the next cycle reads the subject entry, and the evaluate state then evaluates the command,
// writes the subject entry back and loads the output register, waiting there while a
// result still sits untaken in the output register. No new command is accepted until
// the last one leaves the evaluate state, as the two reads share the one read port.
// Reset is immediate: a per-entry written flag is cleared, and an entry never
// written reads as its reset value (entry 0 active with all bits, others
// empty), so no clearing pass is needed.
// The output register frees the input side: a new command is accepted while
// a result still waits; a stalled receiver holds the next command in its
// evaluate cycle until the output register is taken.
module capability_permission_table #(
	parameter int TASKS = cpt_pkg::TASKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 cmd,
	input  logic [cpt_pkg::ID_W-1:0]   actor_id,
	input  logic [cpt_pkg::ID_W-1:0]   subject_id,
	input  logic [cpt_pkg::MASK_W-1:0] perm_mask,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       status,
	output logic                       allowed,
	output logic [cpt_pkg::MASK_W-1:0] caps_out
);
	import cpt_pkg::*;

	localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam logic [ID_W:0] TASKS_V = (ID_W+1)'(TASKS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUBJ,
		ST_EXEC
	} state_t;

	state_t state_q;

	// command word held for the whole sequence
	logic [2:0]        cmd_q;
	logic [ID_W-1:0]   actor_q;
	logic [ID_W-1:0]   subj_q;
	logic [MASK_W-1:0] pm_q;

	// table storage
	entry_t            mem [TASKS];
	logic [TASKS-1:0]  written_q;
	entry_t            rdata_q;
	logic              rd_written_q;
	logic              rd_zero_q;
	entry_t            actor_ent_q;

	logic              accept;
	logic              advance;
	logic [AW-1:0]     rd_addr;
	entry_t            rd_ent;
	entry_t            wr_ent;
	logic              wr_en;
	logic              res_status;
	logic              res_allowed;
	logic [MASK_W-1:0] res_caps;
	logic              actor_ok;
	logic              subj_ok;
	logic              subj_nonzero;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign advance  = (state_q == ST_EXEC) && (!out_valid || out_ready);

	// accept cycle reads the actor, the next one the subject
	assign rd_addr = (state_q == ST_IDLE) ? actor_id[AW-1:0] : subj_q[AW-1:0];

	// an entry never written since reset reads as its reset value
	always_comb begin
		if (rd_written_q) begin
			rd_ent = rdata_q;
		end else if (rd_zero_q) begin
			rd_ent = '{active: 1'b1, mask: CAP_ALL};
		end else begin
			rd_ent = '{active: 1'b0, mask: '0};
		end
	end

	assign actor_ok     = {1'b0, actor_q} < TASKS_V;
	assign subj_ok      = {1'b0, subj_q} < TASKS_V;
	assign subj_nonzero = (subj_q != '0);

	// evaluate the command against actor entry and subject entry (rd_ent)
	always_comb begin
		res_status  = 1'b1;
		res_allowed = 1'b0;
		res_caps    = '0;
		wr_en       = 1'b0;
		wr_ent      = rd_ent;
		case (cmd_q)
			CMD_CREATE: begin
				if (actor_ok && subj_ok && actor_ent_q.active
						&& (actor_ent_q.mask & (CAP_SPAWN | CAP_KERNEL)) != '0
						&& !rd_ent.active) begin
					res_status = 1'b0;
					wr_en      = 1'b1;
					wr_ent     = '{active: 1'b1,
						mask: pm_q | (actor_ent_q.mask
							& ~(CAP_GRANT | CAP_REVOKE | CAP_KERNEL))};
				end
			end
			CMD_DESTROY: begin
				res_status = 1'b0;
				if (subj_ok && subj_nonzero) begin
					wr_en  = 1'b1;
					wr_ent = '{active: 1'b0, mask: '0};
				end
			end
			CMD_GRANT: begin
				if (actor_ok && subj_ok && actor_ent_q.active
						&& (actor_ent_q.mask & (CAP_GRANT | CAP_KERNEL)) != '0
						&& rd_ent.active) begin
					res_status = 1'b0;
					wr_en      = 1'b1;
					wr_ent     = '{active: 1'b1, mask: rd_ent.mask | pm_q};
				end
			end
			CMD_REVOKE: begin
				if (actor_ok && subj_ok && actor_ent_q.active
						&& (actor_ent_q.mask & (CAP_REVOKE | CAP_KERNEL)) != '0
						&& subj_nonzero && rd_ent.active) begin
					res_status = 1'b0;
					wr_en      = 1'b1;
					wr_ent     = '{active: 1'b1, mask: rd_ent.mask & ~pm_q};
				end
			end
			CMD_CHECK: begin
				res_status = 1'b0;
				if (subj_ok && rd_ent.active
						&& (rd_ent.mask[KERNEL_BIT] || (rd_ent.mask & pm_q) == pm_q)) begin
					res_allowed = 1'b1;
				end
			end
			CMD_GET: begin
				res_status = 1'b0;
				if (subj_ok && rd_ent.active) begin
					res_caps = rd_ent.mask;
				end
			end
			default: begin
				res_status = 1'b1;
			end
		endcase
	end

	// memory: registered read, write on the evaluate cycle
	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			mem[subj_q[AW-1:0]] <= wr_ent;
		end
		rdata_q <= mem[rd_addr];
	end

	// sequencer, written flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			written_q    <= '0;
			rd_written_q <= 1'b0;
			rd_zero_q    <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			rd_written_q <= written_q[rd_addr];
			rd_zero_q    <= (rd_addr == '0);
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SUBJ;
					end
				end
				ST_SUBJ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (advance) begin
						if (wr_en) begin
							written_q[subj_q[AW-1:0]] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers: hold command, capture actor entry, load result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			actor_q <= actor_id;
			subj_q  <= subject_id;
			pm_q    <= perm_mask;
		end
		if (state_q == ST_SUBJ) begin
			actor_ent_q <= rd_ent;
		end
		if (advance) begin
			status   <= res_status;
			allowed  <= res_allowed;
			caps_out <= res_caps;
		end
	end

endmodule

// ===== verif/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpt_pkg::*;

	localparam int TASKS         = TASKS_DEF;
	localparam int STALL_LIMIT   = 4000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES  = 16;    // margin after the last result is retired
	localparam int WORDS_A_PHASE = 400;

	// Command codes that the package leaves undefined; the block must reject them.
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	typedef struct packed {
		logic              status;
		logic              allowed;
		logic [MASK_W-1:0] caps;
	} verdict_t;

	// Shadow permission table plus the queue of verdicts still owed by the block.
	class perm_scoreboard;
		logic [MASK_W-1:0] caps_tbl[TASKS];
		bit                live[TASKS];
		verdict_t          owed[$];
		int                errors;
		int                checked;
		int                words_by_cmd[8];
		int                rejects;

		function new();
			for (int i = 0; i < TASKS; i++) begin
				caps_tbl[i] = '0;
				live[i]     = 1'b0;
			end
			caps_tbl[0] = CAP_ALL;
			live[0]     = 1'b1;
		endfunction

		function bit in_table(logic [ID_W-1:0] id);
			return int'(id) < TASKS;
		endfunction

		// KERNEL stands in for any single right.
		function bit holds(logic [ID_W-1:0] id, logic [MASK_W-1:0] right);
			return live[id] && ((caps_tbl[id] & (right | CAP_KERNEL)) != '0);
		endfunction

		// Apply one accepted command to the shadow table and queue its verdict.
		function void note_command(logic [2:0] c, logic [ID_W-1:0] a, logic [ID_W-1:0] s,
				logic [MASK_W-1:0] pm);
			verdict_t v;
			v = '{status: 1'b1, allowed: 1'b0, caps: '0};
			words_by_cmd[c]++;
			case (cmd_t'(c))
				CMD_CREATE: begin
					if (in_table(a) && in_table(s) && holds(a, CAP_SPAWN) && !live[s]) begin
						caps_tbl[s] = pm | (caps_tbl[a] & ~(CAP_GRANT | CAP_REVOKE | CAP_KERNEL));
						live[s]     = 1'b1;
						v.status    = 1'b0;
					end
				end
				CMD_DESTROY: begin
					if (in_table(s) && s != '0) begin
						caps_tbl[s] = '0;
						live[s]     = 1'b0;
					end
					v.status = 1'b0;
				end
				CMD_GRANT: begin
					if (in_table(a) && in_table(s) && holds(a, CAP_GRANT) && live[s]) begin
						caps_tbl[s] = caps_tbl[s] | pm;
						v.status    = 1'b0;
					end
				end
				CMD_REVOKE: begin
					if (in_table(a) && in_table(s) && holds(a, CAP_REVOKE) && s != '0
							&& live[s]) begin
						caps_tbl[s] = caps_tbl[s] & ~pm;
						v.status    = 1'b0;
					end
				end
				CMD_CHECK: begin
					v.status = 1'b0;
					if (in_table(s) && live[s])
						v.allowed = ((caps_tbl[s] & CAP_KERNEL) != '0) || ((caps_tbl[s] & pm) == pm);
				end
				CMD_GET: begin
					v.status = 1'b0;
					if (in_table(s) && live[s])
						v.caps = caps_tbl[s];
				end
				default: ;
			endcase
			if (v.status)
				rejects++;
			owed.push_back(v);
		endfunction

		function void check_result(logic st, logic al, logic [MASK_W-1:0] cp);
			verdict_t exp;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing outstanding, actual status %0b allowed %0b caps %h",
					$time, st, al, cp);
				errors++;
				return;
			end
			exp = owed.pop_front();
			checked++;
			if (st !== exp.status) begin
				$display("%0t: status mismatch, expected %0b actual %0b", $time, exp.status, st);
				errors++;
			end
			if (al !== exp.allowed) begin
				$display("%0t: allowed mismatch, expected %0b actual %0b", $time, exp.allowed, al);
				errors++;
			end
			if (cp !== exp.caps) begin
				$display("%0t: caps_out mismatch, expected %h actual %h", $time, exp.caps, cp);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        cmd;
	logic [ID_W-1:0]   actor_id;
	logic [ID_W-1:0]   subject_id;
	logic [MASK_W-1:0] perm_mask;
	logic              out_valid;
	logic              out_ready;
	logic              status;
	logic              allowed;
	logic [MASK_W-1:0] caps_out;

	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	perm_scoreboard sb = new();

	capability_permission_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.actor_id   (actor_id),
		.subject_id (subject_id),
		.perm_mask  (perm_mask),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.allowed    (allowed),
		.caps_out   (caps_out)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver: drop ready at random at the current stall rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor both channels. Retire the result first so a stray output can never
	// match the verdict of the command accepted on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(status, allowed, caps_out);
			if (in_valid && in_ready)
				sb.note_command(cmd, actor_id, subject_id, perm_mask);
		end
	end

	// Watchdog: count edges where no word moves and bail out on a hang.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, STALL_LIMIT, sb.owed.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Present one command word and hold it until the block takes it. Idle
	// cycles go in front, so valid stays high across back-to-back words.
	task automatic send_word(logic [2:0] c, logic [ID_W-1:0] a, logic [ID_W-1:0] s,
			logic [MASK_W-1:0] pm);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			cmd        <= 3'($urandom);
			actor_id   <= ID_W'($urandom);
			subject_id <= ID_W'($urandom);
			perm_mask  <= MASK_W'($urandom);
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		actor_id   <= a;
		subject_id <= s;
		perm_mask  <= pm;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Slot IDs lean hard on a few low slots so that the table fills up and
	// creates, grants and revokes hit live entries; the top of the table and
	// out-of-range IDs still show up.
	function automatic logic [ID_W-1:0] pick_slot();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return ID_W'($urandom_range(0, 7));
		else if (r < 80)
			return ID_W'($urandom_range(TASKS - 4, TASKS - 1));
		else if (r < 92)
			return ID_W'($urandom_range(8, TASKS - 1));
		else
			return ID_W'($urandom_range(TASKS, 255));
	endfunction

	function automatic logic [MASK_W-1:0] pick_mask();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return MASK_W'($urandom);
		else if (r < 60)
			return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
		else if (r < 75)
			return CAP_SPAWN | CAP_GRANT | CAP_REVOKE | CAP_KERNEL;
		else if (r < 85)
			return '0;
		else
			return MASK_W'($urandom_range(0, 15));
	endfunction

	task automatic send_random_word();
		int               r;
		logic [2:0]       c;
		logic [ID_W-1:0]  a;
		r = $urandom_range(99);
		if (r < 24)      c = CMD_CREATE;
		else if (r < 32) c = CMD_DESTROY;
		else if (r < 50) c = CMD_GRANT;
		else if (r < 65) c = CMD_REVOKE;
		else if (r < 82) c = CMD_CHECK;
		else if (r < 97) c = CMD_GET;
		else             c = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
		// The root holds every right; lean on it so that many commands get past
		// the authority check.
		a = ($urandom_range(99) < 35) ? '0 : pick_slot();
		send_word(c, a, pick_slot(), pick_mask());
	endtask

	task automatic send_directed();
		send_word(CMD_GET,     8'd0,   8'd0,   16'h0000);  // root reads all ones
		send_word(CMD_CHECK,   8'd0,   8'd0,   16'hFFFF);  // KERNEL passes
		send_word(CMD_CREATE,  8'd0,   8'd0,   16'h0001);  // subject equals actor: slot taken
		send_word(CMD_CREATE,  8'd0,   8'd1,   16'h0003);  // inherits, GRANT/REVOKE/KERNEL masked
		send_word(CMD_CREATE,  8'd1,   8'd2,   16'h8000);  // child creates grandchild
		send_word(CMD_CREATE,  8'd0,   8'd63,  16'hFFFF);  // top slot
		send_word(CMD_REVOKE,  8'd0,   8'd1,   CAP_SPAWN);
		send_word(CMD_CREATE,  8'd1,   8'd3,   16'h0000);  // parent lost the spawn right
		send_word(CMD_GRANT,   8'd1,   8'd2,   16'h0001);  // no GRANT right
		send_word(CMD_GRANT,   8'd0,   8'd1,   CAP_GRANT | CAP_REVOKE);
		send_word(CMD_GRANT,   8'd1,   8'd2,   16'h0010);
		send_word(CMD_REVOKE,  8'd1,   8'd0,   16'hFFFF);  // slot zero is protected
		send_word(CMD_REVOKE,  8'd0,   8'd5,   16'h0001);  // inactive target
		send_word(CMD_CREATE,  8'd64,  8'd4,   16'h0000);  // parent out of range
		send_word(CMD_CREATE,  8'd0,   8'd255, 16'h0000);  // slot out of range
		send_word(CMD_GRANT,   8'd255, 8'd1,   16'hFFFF);
		send_word(CMD_CHECK,   8'd0,   8'd1,   16'h0000);  // empty request passes on a live subject
		send_word(CMD_CHECK,   8'd0,   8'd2,   16'hFFFF);  // missing bits, no KERNEL
		send_word(CMD_CHECK,   8'd0,   8'd7,   16'h0000);  // inactive subject
		send_word(CMD_GET,     8'd0,   8'd200, 16'h0000);  // out of range reads zero
		send_word(CMD_DESTROY, 8'd0,   8'd0,   16'h0000);  // root survives, status still ok
		send_word(CMD_DESTROY, 8'd0,   8'd255, 16'h0000);
		send_word(CMD_DESTROY, 8'd0,   8'd2,   16'h0000);
		send_word(CMD_GET,     8'd0,   8'd2,   16'h0000);  // gone after destroy
		send_word(CMD_RSVD6,   8'hFF,  8'hFF,  16'hFFFF);
		send_word(CMD_RSVD7,   8'd0,   8'd1,   16'h0000);
	endtask

	initial begin
		// Hold every input at a known value through reset.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		quiet_cycles  = 0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		out_ready  <= 1'b0;
		cmd        <= CMD_GET;
		actor_id   <= '0;
		subject_id <= '0;
		perm_mask  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 1: busy sender, heavily stalled receiver.
		send_idle_pct = 12;
		recv_idle_pct = 75;
		send_directed();
		repeat (WORDS_A_PHASE) send_random_word();

		// Phase 2: the other way round.
		send_idle_pct = 75;
		recv_idle_pct = 12;
		repeat (WORDS_A_PHASE) send_random_word();

		// Phase 3: full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (WORDS_A_PHASE) send_random_word();
		in_valid <= 1'b0;

		// Drain: the watchdog covers a block that stops answering.
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d create, %0d destroy, %0d grant, %0d revoke, %0d check, %0d get",
			sb.words_by_cmd[CMD_CREATE], sb.words_by_cmd[CMD_DESTROY],
			sb.words_by_cmd[CMD_GRANT], sb.words_by_cmd[CMD_REVOKE],
			sb.words_by_cmd[CMD_CHECK], sb.words_by_cmd[CMD_GET]);
		$display("and %0d unused-code words; %0d results checked, %0d of them rejections",
			sb.words_by_cmd[CMD_RSVD6] + sb.words_by_cmd[CMD_RSVD7], sb.checked, sb.rejects);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/cpt_pkg.sv
sv/capability_permission_table.sv
verif/tb.sv
